// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files, included by chkv_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// ===== sv/chkv_pkg.sv =====
// ----------------------------------------------------------------------------
// chkv_pkg: shared types and constants of the hash key-value store
// Bucket geometry, command codes and the request record between the stages.
// ----------------------------------------------------------------------------
package chkv_pkg;

	localparam int BUCKET_COUNT = 64;
	localparam int CHAIN_DEPTH  = 4;
	localparam int BKT_W        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int CNT_W        = 9;
	localparam int QUEUE_DEPTH  = 2;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef logic [CHAIN_DEPTH-1:0] way_mask_t;

	// classified request handed from front to back
	typedef struct packed {
		cmd_t              cmd;
		logic [BKT_W-1:0]  bucket;
		logic [63:0]       key;
		logic [63:0]       value;
	} req_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_EXEC,
		BK_HOLD
	} bk_state_t;

	// bucket index: key modulo the bucket count
	function automatic logic [BKT_W-1:0] bucket_of(input logic [63:0] k);
		logic [63:0] r;
		r = k % 64'(BUCKET_COUNT);
		return r[BKT_W-1:0];
	endfunction

endpackage

// ===== sv/chkv_stream_if.sv =====
// ----------------------------------------------------------------------------
// chkv_req_if / chkv_rsp_if: valid-ready channels of the store
// One interface per channel direction of payload.
// ----------------------------------------------------------------------------
interface chkv_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] key;
	logic [63:0] value;
	modport source (output valid, cmd, key, value, input ready);
	modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface chkv_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [63:0] old_key;
	logic [63:0] old_value;
	logic        bucket_full;
	logic [8:0]  element_count;
	modport source (output valid, hit, old_key, old_value, bucket_full, element_count,
		input ready);
	modport sink   (input valid, hit, old_key, old_value, bucket_full, element_count,
		output ready);
endinterface

// ===== sv/chkv_front.sv =====
// ----------------------------------------------------------------------------
// chkv_front: request intake and queue
// Takes command beats, works out the bucket and holds them in a short FIFO.
// ----------------------------------------------------------------------------
module chkv_front (
	input  logic                  clk,
	input  logic                  arst_n,
	chkv_req_if.sink              req,
	output logic                  q_valid,
	output chkv_pkg::req_t        q_data,
	input  logic                  q_pop
);

	localparam int PTR_W = $clog2(chkv_pkg::QUEUE_DEPTH);

	chkv_pkg::req_t    fifo_q [chkv_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    fill_q;
	logic              push;
	chkv_pkg::req_t    cls;

	// classify the incoming beat
	always_comb begin
		cls.cmd    = chkv_pkg::cmd_t'(req.cmd);
		cls.bucket = chkv_pkg::bucket_of(req.key);
		cls.key    = req.key;
		cls.value  = req.value;
	end

	assign req.ready = (fill_q != (PTR_W+1)'(chkv_pkg::QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (fill_q != '0);
	assign q_data    = fifo_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			fill_q <= fill_q + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
		end
	end

endmodule

// ===== sv/chkv_back.sv =====
// ----------------------------------------------------------------------------
// chkv_back: bucket row engine
// Reads one bucket row, compares its ways, updates the row on insert or remove, sends result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chkv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  chkv_pkg::req_t        q_data,
	output logic                  q_pop,
	chkv_rsp_if.source            rsp
);

	localparam int D     = chkv_pkg::CHAIN_DEPTH;
	localparam int NB    = chkv_pkg::BUCKET_COUNT;
	localparam int WAY_W = (D > 1) ? $clog2(D) : 1;

	// row memories: one row per bucket, one word per way
	logic [D-1:0][63:0]   key_mem   [NB];
	logic [D-1:0][63:0]   val_mem   [NB];
	logic [D-1:0]         valid_q   [NB];

	chkv_pkg::bk_state_t  state_q, state_d;
	chkv_pkg::req_t       req_q;
	logic [D-1:0][63:0]   rkey_q;
	logic [D-1:0][63:0]   rval_q;
	logic [D-1:0]         rvld_q;
	logic [chkv_pkg::CNT_W-1:0] count_q;

	logic                 hit_q, full_q;
	logic [63:0]          okey_q, oval_q;

	logic [D-1:0]         match, free;
	logic                 any_match, any_free;
	logic [WAY_W-1:0]     match_way, free_way;
	logic                 take, exec;

	// way compare and priority pick
	always_comb begin
		match_way = '0;
		free_way  = '0;
		any_match = 1'b0;
		any_free  = 1'b0;
		for (int w = 0; w < D; w++) begin
			match[w] = rvld_q[w] && (rkey_q[w] == req_q.key);
			free[w]  = !rvld_q[w];
		end
		for (int w = D-1; w >= 0; w--) begin
			if (match[w]) begin
				match_way = WAY_W'(w);
				any_match = 1'b1;
			end
			if (free[w]) begin
				free_way = WAY_W'(w);
				any_free = 1'b1;
			end
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		take    = 1'b0;
		exec    = 1'b0;
		unique case (state_q)
			chkv_pkg::BK_IDLE: begin
				if (q_valid) begin
					take    = 1'b1;
					state_d = chkv_pkg::BK_READ;
				end
			end
			chkv_pkg::BK_READ: state_d = chkv_pkg::BK_EXEC;
			chkv_pkg::BK_EXEC: begin
				exec    = 1'b1;
				state_d = chkv_pkg::BK_HOLD;
			end
			chkv_pkg::BK_HOLD: begin
				if (rsp.ready) state_d = chkv_pkg::BK_IDLE;
			end
			default: state_d = chkv_pkg::BK_IDLE;
		endcase
	end

	assign q_pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chkv_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture and registered row read
	always_ff @(posedge clk) begin
		if (take) req_q <= q_data;
		if (state_q == chkv_pkg::BK_READ) begin
			rkey_q <= key_mem[req_q.bucket];
			rval_q <= val_mem[req_q.bucket];
		end
	end

	// key and value rows: written back at execute
	always_ff @(posedge clk) begin
		if (exec) begin
			if (req_q.cmd == chkv_pkg::CMD_INSERT) begin
				if (any_match) begin
					val_mem[req_q.bucket][match_way] <= req_q.value;
				end else if (any_free) begin
					key_mem[req_q.bucket][free_way] <= req_q.key;
					val_mem[req_q.bucket][free_way] <= req_q.value;
				end
			end
		end
	end

	// valid bits, count and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NB; b++) valid_q[b] <= '0;
			rvld_q  <= '0;
			count_q <= '0;
			hit_q   <= 1'b0;
			full_q  <= 1'b0;
			okey_q  <= '0;
			oval_q  <= '0;
		end else begin
			if (state_q == chkv_pkg::BK_READ) rvld_q <= valid_q[req_q.bucket];
			if (exec) begin
				hit_q  <= 1'b0;
				full_q <= 1'b0;
				okey_q <= '0;
				oval_q <= '0;
				case (req_q.cmd) inside
					chkv_pkg::CMD_INSERT, chkv_pkg::CMD_FIND, chkv_pkg::CMD_REMOVE: begin
						if (any_match) begin
							hit_q  <= 1'b1;
							okey_q <= rkey_q[match_way];
							oval_q <= rval_q[match_way];
							if (req_q.cmd == chkv_pkg::CMD_REMOVE) begin
								valid_q[req_q.bucket][match_way] <= 1'b0;
								if (count_q != '0) count_q <= count_q - 1'b1;
							end
						end else if (req_q.cmd == chkv_pkg::CMD_INSERT) begin
							if (any_free) begin
								valid_q[req_q.bucket][free_way] <= 1'b1;
								count_q <= count_q + 1'b1;
							end else begin
								full_q <= 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign rsp.valid         = (state_q == chkv_pkg::BK_HOLD);
	assign rsp.hit           = hit_q;
	assign rsp.old_key       = okey_q;
	assign rsp.old_value     = oval_q;
	assign rsp.bucket_full   = full_q;
	assign rsp.element_count = count_q;

	`CHK_IMPL(a_hit_not_full, clk, arst_n, rsp.valid, !(rsp.hit && rsp.bucket_full))
	`CHK_NEXT(a_take_reads, clk, arst_n, take, state_q == chkv_pkg::BK_READ)
	`CHK_IMPL(a_miss_zero, clk, arst_n, rsp.valid && !rsp.hit,
		rsp.old_key == '0 && rsp.old_value == '0)

endmodule

// ===== sv/chained_hash_key_value_store_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_key_value_store_core: hashed key-value store, top level
// Channel  | dir | payload
// req      | in  | cmd, key, value
// rsp      | out | hit, old_key, old_value, bucket_full, element_count
// Each command passes the back-end steps in order: take, row read, execute, result.
// The front FIFO keeps accepting beats while a result waits on rsp.ready, until full.
// Reset clears the valid bits and the count at once; key and value rows
// are not cleared. A stalled result holds the back end; the FIFO fills.
// ----------------------------------------------------------------------------
module chained_hash_key_value_store_core (
	input  logic          clk,
	input  logic          arst_n,
	chkv_req_if.sink      req,
	chkv_rsp_if.source    rsp
);

	logic              q_valid;
	logic              q_pop;
	chkv_pkg::req_t    q_data;

	chkv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	chkv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

// ===== bench/tb_chained_hash_key_value_store_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chained_hash_key_value_store_core: self-checking bench of the hashed store
// Drives insert, find, remove and no-op beats with random idling on both channels.
// A behavioural copy of the bucket table predicts every response beat, and
// each response is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_chained_hash_key_value_store_core;

	localparam int SLOTS       = chkv_pkg::BUCKET_COUNT * chkv_pkg::CHAIN_DEPTH;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		chkv_pkg::cmd_t cmd;
		logic [63:0]    key;
		logic [63:0]    value;
	} op_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] old_key;
		logic [63:0] old_value;
		logic        bucket_full;
		logic [8:0]  element_count;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	chkv_req_if req ();
	chkv_rsp_if rsp ();

	chained_hash_key_value_store_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// shadow table
	logic        shadow_valid [SLOTS] = '{default: 1'b0};
	logic [63:0] shadow_key   [SLOTS] = '{default: 64'd0};
	logic [63:0] shadow_value [SLOTS] = '{default: 64'd0};
	int unsigned shadow_count = 0;

	op_t    pending_ops [$];
	reply_t replies_due [$];

	int unsigned mismatches  = 0;
	int unsigned idle_cycles = 0;
	int unsigned n_in        = 0;
	bit          in_taken    = 1'b0;  // input beat accepted at the last rising edge
	bit          calm        = 1'b0;  // no idling in the final stretch
	bit          hold_done   = 1'b0;  // long receiver hold-off already done
	int unsigned snd_gap = 0, rcv_gap = 0, hold_left = 0;

	// key pool: many fresh keys fall in six buckets so chains fill up and remove/find hit often
	logic [63:0] key_pool [$];

	always #5 clk = ~clk;

	// Work out the reply of one operation and update the shadow table
	function automatic reply_t apply_op(op_t o);
		reply_t r;
		int base, s, w;
		r = '0;
		base = int'(o.key % 64'(chkv_pkg::BUCKET_COUNT)) * chkv_pkg::CHAIN_DEPTH;
		s = -1;
		if (o.cmd != chkv_pkg::CMD_NOP) begin
			for (w = 0; w < chkv_pkg::CHAIN_DEPTH; w++) begin
				if (s < 0 && shadow_valid[base+w] && shadow_key[base+w] == o.key)
					s = base + w;
			end
			if (s >= 0) begin
				r.hit = 1'b1;
				r.old_key = shadow_key[s];
				r.old_value = shadow_value[s];
				if (o.cmd == chkv_pkg::CMD_INSERT) begin
					shadow_value[s] = o.value;
				end else if (o.cmd == chkv_pkg::CMD_REMOVE) begin
					shadow_valid[s] = 1'b0;
					if (shadow_count > 0) shadow_count--;
				end
			end else if (o.cmd == chkv_pkg::CMD_INSERT) begin
				r.bucket_full = 1'b1;
				for (w = 0; w < chkv_pkg::CHAIN_DEPTH; w++) begin
					if (r.bucket_full && !shadow_valid[base+w]) begin
						shadow_valid[base+w] = 1'b1;
						shadow_key[base+w] = o.key;
						shadow_value[base+w] = o.value;
						shadow_count++;
						r.bucket_full = 1'b0;
					end
				end
			end
		end
		r.element_count = shadow_count[8:0];
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic op_t make_op(chkv_pkg::cmd_t c, logic [63:0] k, logic [63:0] v);
		op_t o;
		o.cmd = c;
		o.key = k;
		o.value = v;
		return o;
	endfunction

	// Random key: mostly from the pool, sometimes fresh
	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		if ($urandom_range(0, 1))
			k = rand64();
		else
			k = {54'd0, 4'($urandom_range(0, 15)), 6'd0} | 64'($urandom_range(0, 5));
		key_pool.push_back(k);
		return k;
	endfunction

	// Driver: a beat is held until accepted, gaps only between beats
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd   <= chkv_pkg::CMD_NOP;
			req.key   <= '0;
			req.value <= '0;
		end else if (snd_gap > 0) begin
			snd_gap <= snd_gap - 1;
			req.valid <= 1'b0;
		end else if (req.valid && !in_taken) begin
			// beat still waiting: hold it
		end else if (pending_ops.size() > 0) begin
			if (!calm && $urandom_range(0, 9) == 0) begin
				snd_gap <= $urandom_range(0, 15);
				req.valid <= 1'b0;
			end else begin
				req.valid <= 1'b1;
				req.cmd   <= pending_ops[0].cmd;
				req.key   <= pending_ops[0].key;
				req.value <= pending_ops[0].value;
			end
		end else begin
			req.valid <= 1'b0;
		end
	end

	// Predict on acceptance
	always @(posedge clk) begin
		op_t o;
		in_taken <= 1'b0;
		if (arst_n && req.valid && req.ready) begin
			o.cmd = chkv_pkg::cmd_t'(req.cmd);
			o.key = req.key;
			o.value = req.value;
			replies_due.push_back(apply_op(o));
			void'(pending_ops.pop_front());
			in_taken <= 1'b1;
			n_in <= n_in + 1;
		end
	end

	// Receiver ready with random bursts and one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (!hold_done && n_in >= 250) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else if (rcv_gap > 0) begin
			rcv_gap <= rcv_gap - 1;
			rsp.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			rcv_gap <= $urandom_range(0, 15);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Monitor: compare each response beat with the oldest prediction
	always @(posedge clk) begin
		reply_t exp_r, got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.hit, rsp.old_key, rsp.old_value, rsp.bucket_full, rsp.element_count};
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response beat: %p", got);
			end else begin
				exp_r = replies_due.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp_r, got);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT && (pending_ops.size() > 0 ||
				replies_due.size() > 0)) begin
				$display("** chained_hash_key_value_store_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int i, n;
		logic [63:0] k;
		chkv_pkg::cmd_t c;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every command, miss, replace, full chain, unused code
		pending_ops.push_back(make_op(chkv_pkg::CMD_FIND, '0, '1));
		pending_ops.push_back(make_op(chkv_pkg::CMD_REMOVE, '1, '0));
		pending_ops.push_back(make_op(chkv_pkg::CMD_INSERT, '0, '1));
		pending_ops.push_back(make_op(chkv_pkg::CMD_INSERT, '1, '0));
		pending_ops.push_back(make_op(chkv_pkg::CMD_INSERT, '0, 64'h5555_AAAA_5555_AAAA));
		pending_ops.push_back(make_op(chkv_pkg::CMD_FIND, '1, '1));
		for (i = 1; i <= chkv_pkg::CHAIN_DEPTH; i++)
			pending_ops.push_back(make_op(chkv_pkg::CMD_INSERT,
				64'(i * chkv_pkg::BUCKET_COUNT), rand64()));
		pending_ops.push_back(make_op(chkv_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, '1));
		pending_ops.push_back(make_op(chkv_pkg::CMD_INSERT,
			64'(chkv_pkg::BUCKET_COUNT), 64'h1));
		pending_ops.push_back(make_op(chkv_pkg::CMD_NOP, '1, '1));
		pending_ops.push_back(make_op(chkv_pkg::CMD_REMOVE,
			64'(2 * chkv_pkg::BUCKET_COUNT), '1));
		pending_ops.push_back(make_op(chkv_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 64'h7));
		pending_ops.push_back(make_op(chkv_pkg::CMD_FIND, 64'h8000_0000_0000_0000, '0));
		pending_ops.push_back(make_op(chkv_pkg::CMD_REMOVE, '0, '0));
		pending_ops.push_back(make_op(chkv_pkg::CMD_FIND, '0, '0));
		pending_ops.push_back(make_op(chkv_pkg::CMD_FIND, 64'h7FFF_FFFF_FFFF_FFFF, '0));

		// Random: mostly keyed operations against the pool
		n = 0;
		while (n < 740) begin
			if (pending_ops.size() < 8) begin
				k = pick_key();
				case ($urandom_range(0, 19))
					0: c = chkv_pkg::CMD_NOP;
					1, 2, 3, 4, 5, 6, 7, 8, 9: c = chkv_pkg::CMD_INSERT;
					10, 11, 12, 13, 14: c = chkv_pkg::CMD_FIND;
					default: c = chkv_pkg::CMD_REMOVE;
				endcase
				pending_ops.push_back(make_op(c, k, rand64()));
				n++;
				if (n == 640) calm = 1'b1;
			end else begin
				@(posedge clk);
			end
		end

		wait (pending_ops.size() == 0 && replies_due.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("** chained_hash_key_value_store_core: PASSED **");
		end else begin
			$display("** chained_hash_key_value_store_core: FAILED **");
		end
		$finish;
	end

endmodule
